// ===== rtl/tcpcsm_pkg.sv =====
// Package for the TCP connection control block: payload structs, state and
// opcode codes, flag masks, register indexes and small helper functions.
// No dependencies; every other file imports it.
package tcpcsm_pkg;

  localparam int unsigned RX_BUFFER_BYTES = 65536;
  localparam logic [16:0] RX_BYTES = 17'(RX_BUFFER_BYTES);
  localparam logic [15:0] WIN_MAX = 16'd65535;
  localparam logic [10:0] MSS_MIN = 11'd1024;
  localparam logic [10:0] MSS_MAX = 11'd1460;
  localparam logic [10:0] MSS_RESET = 11'd1460;
  localparam logic [31:0] CONNECT_TIMEOUT_RESET = 32'd3000;
  localparam logic [31:0] TIME_WAIT_RESET = 32'd60000;

  localparam logic [5:0] F_FIN = 6'h01;
  localparam logic [5:0] F_SYN = 6'h02;
  localparam logic [5:0] F_RST = 6'h04;
  localparam logic [5:0] F_PSH = 6'h08;
  localparam logic [5:0] F_ACK = 6'h10;

  localparam logic [1:0] CFG_MSS = 2'd0;
  localparam logic [1:0] CFG_CONNECT_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_TIME_WAIT = 2'd2;

  typedef enum logic [2:0] {
    OP_SEGMENT = 3'd0,
    OP_CONNECT = 3'd1,
    OP_LISTEN  = 3'd2,
    OP_CLOSE   = 3'd3,
    OP_WRITE   = 3'd4,
    OP_READ    = 3'd5,
    OP_TIMEOUT = 3'd6,
    OP_UNUSED  = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_CLOSED     = 4'd0,
    ST_LISTEN     = 4'd1,
    ST_CONNECTING = 4'd2,
    ST_SYN_RCVD   = 4'd3,
    ST_ESTAB      = 4'd4,
    ST_FIN_WAIT_1 = 4'd5,
    ST_FIN_WAIT_2 = 4'd6,
    ST_CLOSE_WAIT = 4'd7,
    ST_CLOSING    = 4'd8,
    ST_LAST_ACK   = 4'd9,
    ST_TIME_WAIT  = 4'd10
  } link_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EXEC,
    CS_EMIT0,
    CS_EMIT1,
    CS_WRITE
  } ctl_state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_SEG0,
    EMIT_SEG1,
    EMIT_WSEG
  } emit_sel_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] seg_window;
    logic [15:0] data_length;
    logic [31:0] initial_seq;
    logic [31:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [5:0]  out_flags;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [15:0] out_window;
    logic [10:0] out_length;
    logic [3:0]  conn_state;
    logic        status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [5:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] win;
    logic [10:0] len;
  } seg_t;

  typedef struct packed {
    link_state_t st;
    logic [31:0] snd_una;
    logic [31:0] snd_nxt;
    logic [15:0] snd_wnd;
    logic [31:0] rcv_nxt;
    logic [15:0] rcv_wnd;
    logic [31:0] iss;
    logic [31:0] irs;
    logic [16:0] rcv_buf;
    logic [31:0] timer;
  } conn_t;

  typedef struct packed {
    logic      capture;
    logic      exec;
    emit_sel_t emit;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic exec_write;
    logic two_results;
    logic write_last;
  } dp_sts_t;

  function automatic conn_t conn_clear();
    conn_t c;
    c = '0;
    c.st = ST_CLOSED;
    c.rcv_wnd = WIN_MAX;
    return c;
  endfunction

  // Advertised window for a given buffered byte count, saturated.
  function automatic logic [15:0] window_of(logic [16:0] buffered);
    logic [16:0] room;
    room = (buffered <= RX_BYTES) ? RX_BYTES - buffered : 17'd0;
    return (room > 17'(WIN_MAX)) ? WIN_MAX : room[15:0];
  endfunction

  // Serial-number compare: a strictly before b.
  function automatic logic seq_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  // Serial-number compare: a equal to b or before it.
  function automatic logic seq_not_after(logic [31:0] a, logic [31:0] b);
    return (a == b) || seq_before(a, b);
  endfunction

  function automatic seg_t make_seg(logic [5:0] fl, logic [31:0] sq, logic [31:0] ak,
                                    logic [15:0] wn, logic [10:0] ln);
    seg_t s;
    s.valid = 1'b1;
    s.flags = fl;
    s.seq = sq;
    s.ack = ak;
    s.win = wn;
    s.len = ln;
    return s;
  endfunction

endpackage

// ===== rtl/tcpcsm_ctrl.sv =====
// Controller of the TCP connection block: sequences capture, execute and
// result emission. Depends on tcpcsm_pkg.
module tcpcsm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcpcsm_pkg::dp_sts_t sts,
  output tcpcsm_pkg::dp_cmd_t cmd
);
  import tcpcsm_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_EXEC;
      end
      CS_EXEC: begin
        state_nxt = sts.exec_write ? CS_WRITE : CS_EMIT0;
      end
      CS_EMIT0: begin
        if (sts.out_free) state_nxt = sts.two_results ? CS_EMIT1 : CS_IDLE;
      end
      CS_EMIT1: begin
        if (sts.out_free) state_nxt = CS_IDLE;
      end
      CS_WRITE: begin
        if (sts.out_free && sts.write_last) state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = (state_r != CS_IDLE);
    cmd = '0;
    cmd.emit = EMIT_NONE;
    case (state_r)
      CS_IDLE: begin
        cmd.capture = in_valid;
      end
      CS_EXEC: begin
        cmd.exec = 1'b1;
      end
      CS_EMIT0: begin
        if (sts.out_free) begin
          cmd.emit = EMIT_SEG0;
          cmd.last = !sts.two_results;
        end
      end
      CS_EMIT1: begin
        if (sts.out_free) begin
          cmd.emit = EMIT_SEG1;
          cmd.last = 1'b1;
        end
      end
      CS_WRITE: begin
        if (sts.out_free) begin
          cmd.emit = EMIT_WSEG;
          cmd.last = sts.write_last;
        end
      end
      default: begin
        cmd.emit = EMIT_NONE;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit != EMIT_NONE) |-> sts.out_free)
    else $error("result emitted while output register busy");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == CS_EXEC))
    else $error("accepted item not executed next cycle");

  a_write_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CS_EXEC && sts.exec_write) |=> (state_r == CS_WRITE))
    else $error("write event did not enter segmenting loop");

endmodule

// ===== rtl/tcpcsm_dp.sv =====
// Datapath of the TCP connection block: connection registers, event
// evaluation, result slots, write segmenter and output register.
// Depends on tcpcsm_pkg.
module tcpcsm_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcpcsm_pkg::in_item_t  in_data,
  output tcpcsm_pkg::out_item_t out_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  tcpcsm_pkg::dp_cmd_t   cmd,
  output tcpcsm_pkg::dp_sts_t   sts
);
  import tcpcsm_pkg::*;

  logic [10:0] mss_r;
  logic [31:0] cto_r;
  logic [31:0] twl_r;
  in_item_t    in_r;
  conn_t       conn_r, conn_nxt;
  seg_t        seg0_r, seg0_nxt;
  seg_t        seg1_r, seg1_nxt;
  logic [1:0]  nres_r, nres_nxt;
  logic        status_r, status_nxt;
  logic [15:0] left_r;
  logic        wr_nxt;
  out_item_t   out_r;
  logic        out_valid_r;

  logic [16:0] space_c, take_c, rtake_c;
  logic [10:0] mss_c, wlen_c;
  logic        open_c;
  seg_t        x_c, wseg_c, emit_seg_c;
  op_t         op_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mss_r <= MSS_RESET;
      cto_r <= CONNECT_TIMEOUT_RESET;
      twl_r <= TIME_WAIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MSS:             mss_r <= cfg_data[10:0];
        CFG_CONNECT_TIMEOUT: cto_r <= cfg_data;
        CFG_TIME_WAIT:       twl_r <= cfg_data;
        default:             ;
      endcase
    end
  end

  assign mss_c = (mss_r < MSS_MIN) ? MSS_MIN : ((mss_r > MSS_MAX) ? MSS_MAX : mss_r);
  assign wlen_c = (left_r > 16'(mss_c)) ? mss_c : left_r[10:0];
  assign op_c = op_t'(in_r.opcode);

  always_comb begin
    conn_nxt = conn_r;
    seg0_nxt = '0;
    seg1_nxt = '0;
    nres_nxt = 2'd0;
    status_nxt = 1'b0;
    wr_nxt = 1'b0;
    x_c = '0;
    space_c = '0;
    take_c = '0;
    rtake_c = '0;
    open_c = 1'b0;
    case (op_c)
      OP_SEGMENT: begin
        case (conn_r.st)
          ST_CLOSED: begin
            if ((in_r.seg_flags & F_RST) == '0) begin
              seg0_nxt = make_seg(F_RST | F_ACK, in_r.seg_ack, in_r.seg_seq + 32'd1,
                                  16'd0, 11'd0);
              nres_nxt = 2'd1;
            end
            status_nxt = 1'b1;
          end
          ST_LISTEN: begin
            if ((in_r.seg_flags & F_SYN) != '0) begin
              conn_nxt = conn_clear();
              conn_nxt.iss = in_r.initial_seq;
              conn_nxt.snd_una = in_r.initial_seq;
              conn_nxt.irs = in_r.seg_seq;
              conn_nxt.rcv_nxt = in_r.seg_seq + 32'd1;
              conn_nxt.snd_wnd = in_r.seg_window;
              conn_nxt.st = ST_SYN_RCVD;
              seg0_nxt = make_seg(F_SYN | F_ACK, in_r.initial_seq, conn_nxt.rcv_nxt,
                                  conn_nxt.rcv_wnd, 11'd0);
              nres_nxt = 2'd1;
              conn_nxt.snd_nxt = in_r.initial_seq + 32'd1;
            end
          end
          ST_CONNECTING: begin
            if (((in_r.seg_flags & F_ACK) != '0) &&
                (in_r.seg_ack == conn_r.iss || seq_before(in_r.seg_ack, conn_r.iss) ||
                 seq_before(conn_r.snd_nxt, in_r.seg_ack))) begin
              if ((in_r.seg_flags & F_RST) == '0) begin
                seg0_nxt = make_seg(F_RST | F_ACK, in_r.seg_ack, 32'd0, 16'd0, 11'd0);
                nres_nxt = 2'd1;
              end
              status_nxt = 1'b1;
            end else if ((in_r.seg_flags & F_RST) != '0) begin
              conn_nxt.st = ST_CLOSED;
            end else if ((in_r.seg_flags & F_SYN) != '0) begin
              conn_nxt.irs = in_r.seg_seq;
              conn_nxt.rcv_nxt = in_r.seg_seq + 32'd1;
              conn_nxt.snd_wnd = in_r.seg_window;
              if ((in_r.seg_flags & F_ACK) != '0) conn_nxt.snd_una = in_r.seg_ack;
              nres_nxt = 2'd1;
              if (seq_before(conn_r.iss, conn_nxt.snd_una)) begin
                conn_nxt.st = ST_ESTAB;
                seg0_nxt = make_seg(F_ACK, conn_r.snd_nxt, conn_nxt.rcv_nxt,
                                    conn_r.rcv_wnd, 11'd0);
              end else begin
                conn_nxt.st = ST_SYN_RCVD;
                seg0_nxt = make_seg(F_SYN | F_ACK, conn_r.iss, conn_nxt.rcv_nxt,
                                    conn_r.rcv_wnd, 11'd0);
                conn_nxt.snd_nxt = conn_r.iss + 32'd1;
              end
            end
          end
          ST_SYN_RCVD: begin
            if ((in_r.seg_flags & F_RST) != '0) begin
              conn_nxt.st = ST_CLOSED;
            end else if (((in_r.seg_flags & F_ACK) != '0) &&
                         seq_not_after(conn_r.snd_una, in_r.seg_ack) &&
                         seq_not_after(in_r.seg_ack, conn_r.snd_nxt)) begin
              conn_nxt.st = ST_ESTAB;
              conn_nxt.snd_una = in_r.seg_ack;
            end
          end
          ST_ESTAB: begin
            if ((in_r.seg_flags & F_RST) != '0) begin
              conn_nxt.st = ST_CLOSED;
            end else begin
              if (((in_r.seg_flags & F_ACK) != '0) &&
                  seq_not_after(conn_r.snd_una, in_r.seg_ack) &&
                  seq_not_after(in_r.seg_ack, conn_r.snd_nxt)) begin
                conn_nxt.snd_una = in_r.seg_ack;
              end
              if (in_r.data_length != 16'd0 && in_r.seg_seq == conn_r.rcv_nxt) begin
                space_c = (conn_r.rcv_buf <= RX_BYTES) ? RX_BYTES - conn_r.rcv_buf : 17'd0;
                take_c = (17'(in_r.data_length) < space_c) ? 17'(in_r.data_length)
                                                           : space_c;
                conn_nxt.rcv_buf = conn_r.rcv_buf + take_c;
                conn_nxt.rcv_nxt = conn_r.rcv_nxt + 32'(take_c);
                conn_nxt.rcv_wnd = window_of(conn_nxt.rcv_buf);
                seg0_nxt = make_seg(F_ACK, conn_r.snd_nxt, conn_nxt.rcv_nxt,
                                    conn_nxt.rcv_wnd, 11'd0);
                nres_nxt = 2'd1;
              end
              if ((in_r.seg_flags & F_FIN) != '0) begin
                conn_nxt.rcv_nxt = in_r.seg_seq + 32'(in_r.data_length) + 32'd1;
                conn_nxt.st = ST_CLOSE_WAIT;
                x_c = make_seg(F_ACK, conn_r.snd_nxt, conn_nxt.rcv_nxt,
                               conn_nxt.rcv_wnd, 11'd0);
                if (nres_nxt == 2'd0) seg0_nxt = x_c;
                else seg1_nxt = x_c;
                nres_nxt = nres_nxt + 2'd1;
              end
            end
          end
          ST_FIN_WAIT_1, ST_FIN_WAIT_2: begin
            if (conn_r.st == ST_FIN_WAIT_1 && ((in_r.seg_flags & F_ACK) != '0) &&
                in_r.seg_ack == conn_r.snd_nxt) begin
              conn_nxt.st = ST_FIN_WAIT_2;
            end
            if ((in_r.seg_flags & F_FIN) != '0) begin
              conn_nxt.rcv_nxt = in_r.seg_seq + 32'(in_r.data_length) + 32'd1;
              seg0_nxt = make_seg(F_ACK, conn_r.snd_nxt, conn_nxt.rcv_nxt,
                                  conn_r.rcv_wnd, 11'd0);
              nres_nxt = 2'd1;
              if (conn_nxt.st == ST_FIN_WAIT_2) begin
                conn_nxt.st = ST_TIME_WAIT;
                conn_nxt.timer = in_r.now_ticks;
              end else begin
                conn_nxt.st = ST_CLOSING;
              end
            end
          end
          ST_CLOSING: begin
            if ((in_r.seg_flags & F_ACK) != '0) begin
              conn_nxt.st = ST_TIME_WAIT;
              conn_nxt.timer = in_r.now_ticks;
            end
          end
          ST_LAST_ACK: begin
            if ((in_r.seg_flags & F_ACK) != '0) conn_nxt = conn_clear();
          end
          ST_TIME_WAIT: begin
            if ((in_r.now_ticks - conn_r.timer) > twl_r) conn_nxt = conn_clear();
          end
          default: ;
        endcase
      end
      OP_CONNECT: begin
        if (conn_r.st != ST_CLOSED) begin
          status_nxt = 1'b1;
        end else begin
          conn_nxt = conn_clear();
          conn_nxt.iss = in_r.initial_seq;
          conn_nxt.snd_una = in_r.initial_seq;
          conn_nxt.snd_nxt = in_r.initial_seq + 32'd1;
          conn_nxt.st = ST_CONNECTING;
          conn_nxt.timer = in_r.now_ticks;
          seg0_nxt = make_seg(F_SYN, in_r.initial_seq, 32'd0, WIN_MAX, 11'd0);
          nres_nxt = 2'd1;
        end
      end
      OP_LISTEN: begin
        if (conn_r.st != ST_CLOSED) status_nxt = 1'b1;
        else conn_nxt.st = ST_LISTEN;
      end
      OP_CLOSE: begin
        case (conn_r.st)
          ST_CLOSED, ST_LISTEN, ST_CONNECTING: begin
            conn_nxt = conn_clear();
          end
          ST_SYN_RCVD, ST_ESTAB, ST_CLOSE_WAIT: begin
            seg0_nxt = make_seg(F_FIN | F_ACK, conn_r.snd_nxt, conn_r.rcv_nxt,
                                conn_r.rcv_wnd, 11'd0);
            nres_nxt = 2'd1;
            conn_nxt.snd_nxt = conn_r.snd_nxt + 32'd1;
            conn_nxt.st = (conn_r.st == ST_CLOSE_WAIT) ? ST_LAST_ACK : ST_FIN_WAIT_1;
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        if (in_r.data_length == 16'd0 || conn_r.st != ST_ESTAB) status_nxt = 1'b1;
        else wr_nxt = 1'b1;
      end
      OP_READ: begin
        open_c = (conn_r.st == ST_ESTAB) || (conn_r.st == ST_FIN_WAIT_1) ||
                 (conn_r.st == ST_FIN_WAIT_2) || (conn_r.st == ST_CLOSE_WAIT);
        if (in_r.data_length == 16'd0 || (!open_c && conn_r.rcv_buf == 17'd0)) begin
          status_nxt = 1'b1;
        end else begin
          rtake_c = (conn_r.rcv_buf < 17'(in_r.data_length)) ? conn_r.rcv_buf
                                                             : 17'(in_r.data_length);
          conn_nxt.rcv_buf = conn_r.rcv_buf - rtake_c;
          conn_nxt.rcv_wnd = window_of(conn_nxt.rcv_buf);
        end
      end
      OP_TIMEOUT: begin
        if (conn_r.st == ST_CONNECTING && (in_r.now_ticks - conn_r.timer) > cto_r) begin
          conn_nxt = conn_clear();
          status_nxt = 1'b1;
        end else if (conn_r.st == ST_TIME_WAIT &&
                     (in_r.now_ticks - conn_r.timer) > twl_r) begin
          conn_nxt = conn_clear();
        end
      end
      default: begin
        status_nxt = 1'b1;
      end
    endcase
  end

  assign wseg_c = make_seg(F_ACK | F_PSH, conn_r.snd_nxt, conn_r.rcv_nxt, conn_r.rcv_wnd,
                           wlen_c);

  always_comb begin
    case (cmd.emit)
      EMIT_SEG0: emit_seg_c = seg0_r;
      EMIT_SEG1: emit_seg_c = seg1_r;
      EMIT_WSEG: emit_seg_c = wseg_c;
      default:   emit_seg_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r <= conn_clear();
      nres_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        conn_r <= conn_nxt;
        nres_r <= nres_nxt;
      end else if (cmd.emit == EMIT_WSEG) begin
        conn_r.snd_nxt <= conn_r.snd_nxt + 32'(wlen_c);
      end
      if (cmd.emit != EMIT_NONE) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.exec) begin
      seg0_r <= seg0_nxt;
      seg1_r <= seg1_nxt;
      status_r <= status_nxt;
      left_r <= in_r.data_length;
    end else if (cmd.emit == EMIT_WSEG) begin
      left_r <= left_r - 16'(wlen_c);
    end
    if (cmd.emit != EMIT_NONE) begin
      out_r.send_valid <= emit_seg_c.valid;
      out_r.out_flags <= emit_seg_c.flags;
      out_r.out_seq <= emit_seg_c.seq;
      out_r.out_ack <= emit_seg_c.ack;
      out_r.out_window <= emit_seg_c.win;
      out_r.out_length <= emit_seg_c.len;
      out_r.conn_state <= conn_r.st;
      out_r.status <= status_r;
      out_r.last <= cmd.last;
    end
  end

  assign out_data = out_r;
  assign out_valid = out_valid_r;

  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.exec_write = wr_nxt;
  assign sts.two_results = (nres_r == 2'd2);
  assign sts.write_last = (left_r <= 16'(mss_c));

endmodule

// ===== rtl/tcp_connection_state_machine.sv =====
// TCP connection control block, top level. An accepted event is
// registered, evaluated the next cycle, and its first result beat goes into the
// output register once that register is free (out_valid then high).
// One event at a time; an event gives N result beats (N up to 64 for a
// write), one beat per cycle out of the single output register while
// out_stall is low. Reset (rst_n low, synchronous) returns to CLOSED.
module tcp_connection_state_machine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tcpcsm_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tcpcsm_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import tcpcsm_pkg::*;

  // Commands go from the controller to the datapath; status comes back.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller owns the input handshake and the emission order.
  tcpcsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the connection registers, the configuration
  // registers, the result slots and the output register. Reset also
  // clears the sequence state and restores the register defaults.
  tcpcsm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== dv/tcp_connection_state_machine_test.sv =====
// Self-checking testbench for the TCP connection control block: a scoreboard
// class predicts result beats per event and checks them in order.
// Depends on tcpcsm_pkg and tcp_connection_state_machine.
module tcp_connection_state_machine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcpcsm_pkg::*;

  // Scoreboard: its own copy of the connection control block. note_event
  // predicts the result beats of one accepted event; check_result compares
  // one received beat against the oldest prediction.
  class conn_scoreboard;
    logic [10:0] mss_reg;
    logic [31:0] conn_to_reg;
    logic [31:0] tw_reg;
    link_state_t st;
    logic [31:0] snd_una, snd_nxt, rcv_nxt, iss, irs, timer;
    logic [15:0] snd_wnd;
    logic [16:0] rcv_wnd, rcv_buf;
    out_item_t   pending[$];
    out_item_t   segs[$];
    int          errors;

    function new();
      mss_reg = MSS_RESET;
      conn_to_reg = CONNECT_TIMEOUT_RESET;
      tw_reg = TIME_WAIT_RESET;
      errors = 0;
      clear_conn();
    endfunction

    function void clear_conn();
      st = ST_CLOSED;
      snd_una = 0; snd_nxt = 0; snd_wnd = 0; rcv_nxt = 0;
      rcv_wnd = 17'd65535; iss = 0; irs = 0; rcv_buf = 0; timer = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == CFG_MSS) mss_reg = val[10:0];
      else if (idx == CFG_CONNECT_TIMEOUT) conn_to_reg = val;
      else if (idx == CFG_TIME_WAIT) tw_reg = val;
    endfunction

    function bit lt(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
    endfunction

    function bit le(logic [31:0] a, logic [31:0] b);
      return a == b || lt(a, b);
    endfunction

    function void push_seg(logic [5:0] fl, logic [31:0] sq, logic [31:0] ak,
                           logic [15:0] wn, logic [10:0] ln);
      out_item_t r;
      r = '0;
      r.send_valid = 1'b1;
      r.out_flags = fl; r.out_seq = sq; r.out_ack = ak;
      r.out_window = wn; r.out_length = ln;
      if (segs.size() < 64) segs.push_back(r);
    endfunction

    // Segment sent from the connection; it consumes sequence space.
    function void send_own(logic [5:0] fl, logic [15:0] ln);
      push_seg(fl, snd_nxt, rcv_nxt, rcv_wnd[15:0], ln[10:0]);
      snd_nxt += 32'(ln);
      if (fl & F_SYN) snd_nxt += 1;
      if (fl & F_FIN) snd_nxt += 1;
    endfunction

    function void recompute_window();
      logic [16:0] room;
      room = (rcv_buf <= 17'h10000) ? 17'h10000 - rcv_buf : 17'd0;
      rcv_wnd = room > 17'd65535 ? 17'd65535 : room;
    endfunction

    function void begin_conn(logic [31:0] isn);
      clear_conn();
      iss = isn; snd_una = isn; snd_nxt = isn;
    endfunction

    function bit segment_event(in_item_t e);
      logic [16:0] space, take;
      case (st)
        ST_CLOSED: begin
          if (!(e.seg_flags & F_RST))
            push_seg(F_RST | F_ACK, e.seg_ack, e.seg_seq + 1, 0, 0);
          return 1;
        end
        ST_LISTEN: begin
          if (e.seg_flags & F_SYN) begin
            begin_conn(e.initial_seq);
            irs = e.seg_seq; rcv_nxt = e.seg_seq + 1; snd_wnd = e.seg_window;
            st = ST_SYN_RCVD;
            send_own(F_SYN | F_ACK, 0);
          end
        end
        ST_CONNECTING: begin
          if ((e.seg_flags & F_ACK) &&
              (le(e.seg_ack, iss) || lt(snd_nxt, e.seg_ack))) begin
            if (!(e.seg_flags & F_RST)) push_seg(F_RST | F_ACK, e.seg_ack, 0, 0, 0);
            return 1;
          end
          if (e.seg_flags & F_RST) begin
            st = ST_CLOSED;
            return 0;
          end
          if (e.seg_flags & F_SYN) begin
            irs = e.seg_seq; rcv_nxt = e.seg_seq + 1; snd_wnd = e.seg_window;
            if (e.seg_flags & F_ACK) snd_una = e.seg_ack;
            if (lt(iss, snd_una)) begin
              st = ST_ESTAB;
              send_own(F_ACK, 0);
            end else begin
              // Simultaneous open: SYN|ACK goes out again from the initial sequence.
              st = ST_SYN_RCVD;
              push_seg(F_SYN | F_ACK, iss, rcv_nxt, rcv_wnd[15:0], 0);
              snd_nxt = iss + 1;
            end
          end
        end
        ST_SYN_RCVD: begin
          if (e.seg_flags & F_RST) st = ST_CLOSED;
          else if ((e.seg_flags & F_ACK) && le(snd_una, e.seg_ack) &&
                   le(e.seg_ack, snd_nxt)) begin
            st = ST_ESTAB;
            snd_una = e.seg_ack;
          end
        end
        ST_ESTAB: begin
          if (e.seg_flags & F_RST) begin
            st = ST_CLOSED;
            return 0;
          end
          if ((e.seg_flags & F_ACK) && le(snd_una, e.seg_ack) && le(e.seg_ack, snd_nxt))
            snd_una = e.seg_ack;
          if (e.data_length > 0 && e.seg_seq == rcv_nxt) begin
            space = (rcv_buf <= 17'h10000) ? 17'h10000 - rcv_buf : 17'd0;
            take = (17'(e.data_length) < space) ? 17'(e.data_length) : space;
            rcv_buf += take;
            rcv_nxt += 32'(take);
            recompute_window();
            send_own(F_ACK, 0);
          end
          if (e.seg_flags & F_FIN) begin
            rcv_nxt = e.seg_seq + 32'(e.data_length) + 1;
            st = ST_CLOSE_WAIT;
            send_own(F_ACK, 0);
          end
        end
        ST_FIN_WAIT_1: begin
          if ((e.seg_flags & F_ACK) && e.seg_ack == snd_nxt) st = ST_FIN_WAIT_2;
          if (e.seg_flags & F_FIN) begin
            rcv_nxt = e.seg_seq + 32'(e.data_length) + 1;
            send_own(F_ACK, 0);
            if (st == ST_FIN_WAIT_2) begin
              st = ST_TIME_WAIT;
              timer = e.now_ticks;
            end else begin
              st = ST_CLOSING;
            end
          end
        end
        ST_FIN_WAIT_2: begin
          if (e.seg_flags & F_FIN) begin
            rcv_nxt = e.seg_seq + 32'(e.data_length) + 1;
            send_own(F_ACK, 0);
            st = ST_TIME_WAIT;
            timer = e.now_ticks;
          end
        end
        ST_CLOSING: begin
          if (e.seg_flags & F_ACK) begin
            st = ST_TIME_WAIT;
            timer = e.now_ticks;
          end
        end
        ST_LAST_ACK: if (e.seg_flags & F_ACK) clear_conn();
        ST_TIME_WAIT: if (e.now_ticks - timer > tw_reg) clear_conn();
        default: ;
      endcase
      return 0;
    endfunction

    function void note_event(in_item_t e);
      bit          rej;
      logic [15:0] left, chunk, mss;
      out_item_t   r;
      int          n;
      rej = 0;
      segs.delete();
      case (op_t'(e.opcode))
        OP_SEGMENT: rej = segment_event(e);
        OP_CONNECT: begin
          if (st != ST_CLOSED) rej = 1;
          else begin
            begin_conn(e.initial_seq);
            st = ST_CONNECTING;
            timer = e.now_ticks;
            send_own(F_SYN, 0);
          end
        end
        OP_LISTEN: begin
          if (st != ST_CLOSED) rej = 1;
          else st = ST_LISTEN;
        end
        OP_CLOSE: begin
          case (st)
            ST_CLOSED, ST_LISTEN, ST_CONNECTING: clear_conn();
            ST_SYN_RCVD, ST_ESTAB: begin
              send_own(F_FIN | F_ACK, 0);
              st = ST_FIN_WAIT_1;
            end
            ST_CLOSE_WAIT: begin
              send_own(F_FIN | F_ACK, 0);
              st = ST_LAST_ACK;
            end
            default: ;
          endcase
        end
        OP_WRITE: begin
          if (e.data_length == 0 || st != ST_ESTAB) rej = 1;
          else begin
            mss = 16'(mss_reg);
            if (mss < 16'(MSS_MIN)) mss = 16'(MSS_MIN);
            if (mss > 16'(MSS_MAX)) mss = 16'(MSS_MAX);
            left = e.data_length;
            while (left > 0) begin
              chunk = left > mss ? mss : left;
              send_own(F_ACK | F_PSH, chunk);
              left -= chunk;
            end
          end
        end
        OP_READ: begin
          if (e.data_length == 0 ||
              (!(st inside {ST_ESTAB, ST_FIN_WAIT_1, ST_FIN_WAIT_2, ST_CLOSE_WAIT}) &&
               rcv_buf == 0)) rej = 1;
          else begin
            rcv_buf -= (rcv_buf < 17'(e.data_length)) ? rcv_buf : 17'(e.data_length);
            recompute_window();
          end
        end
        OP_TIMEOUT: begin
          if (st == ST_CONNECTING && e.now_ticks - timer > conn_to_reg) begin
            clear_conn();
            rej = 1;
          end else if (st == ST_TIME_WAIT && e.now_ticks - timer > tw_reg) begin
            clear_conn();
          end
        end
        default: rej = 1;
      endcase
      if (segs.size() == 0) segs.push_back(out_item_t'('0));
      n = segs.size();
      for (int k = 0; k < n; k++) begin
        r = segs[k];
        r.conn_state = st;
        r.status = rej;
        r.last = (k == n - 1);
        pending.push_back(r);
      end
    endfunction

    function void fail(string name, logic [31:0] want, logic [31:0] got);
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.send_valid !== want.send_valid) fail("send_valid", want.send_valid, got.send_valid);
      if (got.out_flags !== want.out_flags) fail("out_flags", want.out_flags, got.out_flags);
      if (got.out_seq !== want.out_seq) fail("out_seq", want.out_seq, got.out_seq);
      if (got.out_ack !== want.out_ack) fail("out_ack", want.out_ack, got.out_ack);
      if (got.out_window !== want.out_window) fail("out_window", want.out_window, got.out_window);
      if (got.out_length !== want.out_length) fail("out_length", want.out_length, got.out_length);
      if (got.conn_state !== want.conn_state) fail("conn_state", want.conn_state, got.conn_state);
      if (got.status !== want.status) fail("status", want.status, got.status);
      if (got.last !== want.last) fail("last", want.last, got.last);
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 1_500_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  conn_scoreboard sb = new();
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  tcp_connection_state_machine DUT (.*);

  always #6 clk = ~clk;

  // Result side: random stall, and every accepted beat goes to the scoreboard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < stall_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drives one event beat, with a random idle gap first. The valid is held
  // until the block stops stalling, and the prediction is made on acceptance.
  // The block stalls in the cycle after an acceptance, so the extra edge
  // after dropping valid costs no throughput.
  task automatic send_event(in_item_t e);
    while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= e;
    do @(posedge clk); while (in_stall);
    sb.note_event(e);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every predicted beat is back, then lets the block settle.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_event(op_t op, logic [5:0] fl, logic [31:0] sq,
                                          logic [31:0] ak, logic [15:0] len);
    in_item_t e;
    e.opcode = op; e.seg_flags = fl; e.seg_seq = sq; e.seg_ack = ak;
    e.seg_window = 16'($urandom); e.data_length = len;
    e.initial_seq = $urandom; e.now_ticks = $urandom;
    return e;
  endfunction

  // A well-formed connection life with random content: open, data in both
  // directions, then one of the closing paths. Acks mostly hit the block's
  // own sequence numbers so that the states beyond the handshake are reached.
  task automatic connection_life();
    in_item_t e;
    logic [31:0] peer;
    int n;
    peer = $urandom;
    if ($urandom_range(1)) begin
      send_event(make_event(OP_LISTEN, 0, 0, 0, 0));
      send_event(make_event(OP_SEGMENT, F_SYN, peer, 0, 0));
      send_event(make_event(OP_SEGMENT, F_ACK, peer + 1, sb.snd_nxt, 0));
    end else begin
      send_event(make_event(OP_CONNECT, 0, 0, 0, 0));
      if ($urandom_range(3) == 0) begin
        send_event(make_event(OP_SEGMENT, F_SYN, peer, 0, 0));
        send_event(make_event(OP_SEGMENT, F_ACK, peer + 1, sb.snd_nxt, 0));
      end else begin
        send_event(make_event(OP_SEGMENT, F_SYN | F_ACK, peer, sb.snd_nxt, 0));
      end
    end
    n = $urandom_range(6);
    repeat (n) begin
      case ($urandom_range(3))
        0: send_event(make_event(OP_WRITE, 0, 0, 0,
                                 16'($urandom_range(9) == 0 ? $urandom
                                                            : $urandom_range(3000))));
        1: send_event(make_event(OP_SEGMENT, F_ACK | ($urandom_range(1) ? F_PSH : 6'h00),
                                 sb.rcv_nxt, sb.snd_nxt, 16'($urandom)));
        2: send_event(make_event(OP_READ, 0, 0, 0, 16'($urandom)));
        default: send_event(make_event(OP_SEGMENT, 6'($urandom), $urandom, $urandom,
                                       16'($urandom)));
      endcase
    end
    if ($urandom_range(1)) begin
      send_event(make_event(OP_CLOSE, 0, 0, 0, 0));
      if ($urandom_range(1))
        send_event(make_event(OP_SEGMENT, F_ACK, sb.rcv_nxt, sb.snd_nxt, 0));
      send_event(make_event(OP_SEGMENT, F_FIN | F_ACK, sb.rcv_nxt, sb.snd_nxt,
                            16'($urandom_range(100))));
      send_event(make_event(OP_SEGMENT, F_ACK, sb.rcv_nxt, sb.snd_nxt, 0));
    end else begin
      send_event(make_event(OP_SEGMENT, F_FIN | F_ACK, sb.rcv_nxt, sb.snd_nxt, 0));
      send_event(make_event(OP_CLOSE, 0, 0, 0, 0));
      send_event(make_event(OP_SEGMENT, F_ACK, sb.rcv_nxt, sb.snd_nxt, 0));
    end
    e = make_event(OP_TIMEOUT, 0, 0, 0, 0);
    e.now_ticks = $urandom_range(1) ? sb.timer + sb.tw_reg + 1 : sb.timer + 5;
    send_event(e);
    send_event(make_event(OP_CLOSE, 0, 0, 0, 0));
  endtask

  task automatic random_event();
    in_item_t e;
    e = make_event(op_t'(3'($urandom_range(7))), 6'($urandom), $urandom, $urandom,
                   16'($urandom));
    if ($urandom_range(1)) e.seg_ack = sb.snd_nxt;
    if (e.opcode == OP_WRITE)
      e.data_length = 16'($urandom_range(4) == 0 ? $urandom : $urandom_range(4000));
    send_event(e);
  endtask

  // A connection life averages about eleven events.
  task automatic random_phase(int n);
    int done;
    done = 0;
    while (done < n) begin
      if ($urandom_range(3) != 0) begin
        connection_life();
        done += 11;
      end else begin
        random_event();
        done++;
      end
    end
  endtask

  initial begin
    in_item_t e;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: segment in CLOSED with and without RST, unused opcode,
    // rejected write and read, extremes of the header fields.
    send_event(make_event(OP_SEGMENT, F_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    send_event(make_event(OP_SEGMENT, 6'h3F, 0, 0, 16'hFFFF));
    send_event(make_event(OP_UNUSED, 6'h3F, 32'hFFFF_FFFF, 0, 16'hFFFF));
    send_event(make_event(OP_WRITE, 0, 0, 0, 100));
    send_event(make_event(OP_READ, 0, 0, 0, 0));
    // Connect, bad ACK while the SYN is out, then a timeout that gives up.
    e = make_event(OP_CONNECT, 0, 0, 0, 0);
    e.now_ticks = 32'hFFFF_FF00;
    send_event(e);
    send_event(make_event(OP_SEGMENT, F_ACK, 7, sb.iss, 0));
    send_event(make_event(OP_CONNECT, 0, 0, 0, 0));
    send_event(make_event(OP_LISTEN, 0, 0, 0, 0));
    e = make_event(OP_TIMEOUT, 0, 0, 0, 0);
    e.now_ticks = sb.timer + 3001;
    send_event(e);
    // Passive open, a full-size write, full-size data in, and a read.
    send_event(make_event(OP_LISTEN, 0, 0, 0, 0));
    send_event(make_event(OP_SEGMENT, F_SYN, 32'hFFFF_FFFF, 0, 0));
    send_event(make_event(OP_SEGMENT, F_ACK, 0, sb.snd_nxt, 0));
    send_event(make_event(OP_WRITE, 0, 0, 0, 16'hFFFF));
    send_event(make_event(OP_SEGMENT, F_ACK, sb.rcv_nxt, sb.snd_nxt, 16'hFFFF));
    send_event(make_event(OP_SEGMENT, F_ACK, sb.rcv_nxt, sb.snd_nxt, 16'hFFFF));
    send_event(make_event(OP_READ, 0, 0, 0, 16'hFFFF));
    send_event(make_event(OP_SEGMENT, F_FIN, sb.rcv_nxt, sb.snd_nxt, 5));
    send_event(make_event(OP_CLOSE, 0, 0, 0, 0));
    send_event(make_event(OP_SEGMENT, F_ACK, 0, sb.snd_nxt, 0));
    // Simultaneous open.
    send_event(make_event(OP_CONNECT, 0, 0, 0, 0));
    send_event(make_event(OP_SEGMENT, F_SYN, $urandom, 0, 0));
    send_event(make_event(OP_SEGMENT, F_RST, 0, 0, 0));

    // The sender waits for every result before going on.
    drain();

    // Settings go from reset values to the extremes and back, covering
    // clamped segment sizes and very short and very long timers.
    write_reg(CFG_MSS, 11'd1024);
    write_reg(CFG_CONNECT_TIMEOUT, 32'd1);
    write_reg(CFG_TIME_WAIT, 32'd1);
    random_phase(100);
    sender_idle_pct = 48;
    write_reg(CFG_MSS, 11'h7FF);
    write_reg(CFG_CONNECT_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_TIME_WAIT, 32'hFFFF_FFFF);
    random_phase(120);
    sender_idle_pct = 0;
    stall_pct = 48;
    write_reg(CFG_MSS, 11'd5);
    write_reg(CFG_TIME_WAIT, 32'd60000);
    random_phase(120);
    sender_idle_pct = 28;
    stall_pct = 28;
    write_reg(CFG_MSS, 11'd1460);
    write_reg(CFG_CONNECT_TIMEOUT, 32'd3000);
    random_phase(120);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
